FILE: src/bqdp_pkg.sv
// Shared types and constants for the bounded handle queue with drop policy.
package bqdp_pkg;

  localparam int unsigned DEPTH_DEF       = 16;
  localparam int unsigned HANDLE_BITS_DEF = 16;

  // fill limit register
  localparam int unsigned    MAXC_W     = 5;
  localparam logic [4:0]     MAXC_RESET = 5'd16;
  localparam int unsigned    PADDR_W    = 3;
  localparam int unsigned    PDATA_W    = 32;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_TAKE   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  localparam logic [1:0] POL_REPLACE_NEWEST = 2'd0;
  localparam logic [1:0] POL_EVICT_OLDEST   = 2'd1;
  localparam logic [1:0] POL_REFUSE         = 2'd2;

  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_EVAL,
    CS_COMMIT
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic eval;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_stall;
  } ctrl_stat_t;

endpackage

FILE: src/bounded_queue_with_drop_policy_unit.sv
// Top level of the bounded handle queue with overflow drop policy.
// A request is captured when accepted, its match prefix is registered in the
// evaluate step and its result in the commit step of the sequencer; a new request
// is taken only when idle or in the commit step, and a result not taken downstream holds the commit step.
// Reset (rst_ni, asynchronous, active low) empties the queue, sets the fill
// limit to 16 and clears the result valid flag; entries and result fields are not reset.
module bounded_queue_with_drop_policy_unit
  import bqdp_pkg::*;
#(
  parameter int unsigned DEPTH       = DEPTH_DEF,
  parameter int unsigned HANDLE_BITS = HANDLE_BITS_DEF,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   req_valid_i,
  output logic                   req_ready_o,
  input  logic [1:0]             action_i,
  input  logic [HANDLE_BITS-1:0] task_handle_i,
  input  logic [1:0]             overflow_policy_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output logic [1:0]             status_o,
  output logic [HANDLE_BITS-1:0] out_handle_o,
  output logic                   out_valid_o,
  output logic                   dropped_o,
  output logic [CW-1:0]          entry_count_o,
  output logic                   is_empty_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [PDATA_W-1:0]     pwdata,
  output logic [PDATA_W-1:0]     prdata,
  output logic                   pready
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  bqdp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bqdp_dp #(
    .DEPTH       (DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .action_i          (action_i),
    .task_handle_i     (task_handle_i),
    .overflow_policy_i (overflow_policy_i),
    .res_valid_o       (res_valid_o),
    .res_ready_i       (res_ready_i),
    .status_o          (status_o),
    .out_handle_o      (out_handle_o),
    .out_valid_o       (out_valid_o),
    .dropped_o         (dropped_o),
    .entry_count_o     (entry_count_o),
    .is_empty_o        (is_empty_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

endmodule

FILE: src/bqdp_ctrl.sv
// Sequencing state machine: capture a request, evaluate matches, commit the update.
module bqdp_ctrl
  import bqdp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  ctrl_stat_t stat_i,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      CS_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = CS_EVAL;
        end
      end
      CS_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = CS_COMMIT;
      end
      CS_COMMIT: begin
        // hold while the previous result still waits downstream
        if (!stat_i.out_stall) begin
          cmd_o.commit = 1'b1;
          req_ready_o  = 1'b1;
          if (req_valid_i) begin
            cmd_o.capture = 1'b1;
            state_d       = CS_EVAL;
          end else begin
            state_d = CS_IDLE;
          end
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

endmodule

FILE: src/bqdp_dp.sv
// Queue storage, match search, compaction, limit register and result register.
module bqdp_dp
  import bqdp_pkg::*;
#(
  parameter int unsigned DEPTH       = DEPTH_DEF,
  parameter int unsigned HANDLE_BITS = HANDLE_BITS_DEF,
  localparam int unsigned IW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ctrl_cmd_t              cmd_i,
  output ctrl_stat_t             stat_o,
  input  logic [1:0]             action_i,
  input  logic [HANDLE_BITS-1:0] task_handle_i,
  input  logic [1:0]             overflow_policy_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output logic [1:0]             status_o,
  output logic [HANDLE_BITS-1:0] out_handle_o,
  output logic                   out_valid_o,
  output logic                   dropped_o,
  output logic [CW-1:0]          entry_count_o,
  output logic                   is_empty_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [PDATA_W-1:0]     pwdata,
  output logic [PDATA_W-1:0]     prdata,
  output logic                   pready
);

  localparam int unsigned LW = (CW > MAXC_W) ? CW : MAXC_W;

  logic [HANDLE_BITS-1:0] entries_q [DEPTH];
  logic [HANDLE_BITS-1:0] entries_up [DEPTH];
  logic [CW-1:0]          fill_q, fill_d;
  logic [MAXC_W-1:0]      maxc_q;

  action_e                act_q;
  logic [HANDLE_BITS-1:0] hnd_q;
  logic [1:0]             pol_q;
  logic [DEPTH-1:0]       pref_q, pref_d;

  logic                   res_valid_q;
  logic [1:0]             status_q, status_d;
  logic [HANDLE_BITS-1:0] oh_q, oh_d;
  logic                   ov_q, ov_d;
  logic                   drop_q, drop_d;
  logic [CW-1:0]          cnt_q;

  logic [LW-1:0]          maxc_ext, lim;
  logic                   full;
  logic [IW-1:0]          fill_idx, tail_idx;
  logic [DEPTH-1:0]       shift;
  logic                   wr_en;
  logic [IW-1:0]          wr_idx;

  // configuration port
  assign pready = 1'b1;
  assign prdata = paddr[2] ? '0 : {{(PDATA_W - MAXC_W){1'b0}}, maxc_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxc_q <= MAXC_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      maxc_q <= pwdata[MAXC_W-1:0];
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q <= action_e'(action_i);
      hnd_q <= task_handle_i;
      pol_q <= overflow_policy_i;
    end
  end

  // prefix of the first match: every entry at or above it moves down one place
  always_comb begin
    logic run;
    run = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      run       = run | ((entries_q[i] == hnd_q) && (CW'(i) < fill_q));
      pref_d[i] = run;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      pref_q <= pref_d;
    end
  end

  // neighbour above each entry, for compaction
  for (genvar g = 0; g < DEPTH; g++) begin : g_up
    if (g == DEPTH - 1) begin : g_top
      assign entries_up[g] = entries_q[g];
    end else begin : g_mid
      assign entries_up[g] = entries_q[g + 1];
    end
  end

  assign maxc_ext = LW'(maxc_q);
  always_comb begin
    if (maxc_q == '0) begin
      lim = LW'(1);
    end else if (maxc_ext > LW'(DEPTH)) begin
      lim = LW'(DEPTH);
    end else begin
      lim = maxc_ext;
    end
  end

  assign full     = LW'(fill_q) >= lim;
  assign fill_idx = fill_q[IW-1:0];
  assign tail_idx = IW'(fill_q - CW'(1));

  always_comb begin
    fill_d   = fill_q;
    status_d = STAT_DONE;
    oh_d     = '0;
    ov_d     = 1'b0;
    drop_d   = 1'b0;
    shift    = '0;
    wr_en    = 1'b0;
    wr_idx   = fill_idx;
    unique case (act_q)
      ACT_ADD: begin
        if (!full) begin
          wr_en  = 1'b1;
          fill_d = fill_q + CW'(1);
        end else begin
          case (pol_q)
            POL_REPLACE_NEWEST: begin
              oh_d   = entries_q[tail_idx];
              wr_en  = 1'b1;
              wr_idx = tail_idx;
              ov_d   = 1'b1;
              drop_d = 1'b1;
            end
            POL_EVICT_OLDEST: begin
              // drop the head, then append at the old tail place
              oh_d   = entries_q[0];
              shift  = '1;
              wr_en  = 1'b1;
              wr_idx = tail_idx;
              ov_d   = 1'b1;
              drop_d = 1'b1;
            end
            default: begin
              status_d = STAT_FULL;
            end
          endcase
        end
      end
      ACT_REMOVE: begin
        if (pref_q[DEPTH-1]) begin
          shift  = pref_q;
          fill_d = fill_q - CW'(1);
        end else begin
          status_d = STAT_MISS;
        end
      end
      ACT_TAKE: begin
        if (fill_q == '0) begin
          status_d = STAT_MISS;
        end else begin
          oh_d   = entries_q[0];
          ov_d   = 1'b1;
          shift  = '1;
          fill_d = fill_q - CW'(1);
        end
      end
      ACT_CLEAR: begin
        fill_d = '0;
      end
      default: begin
        fill_d = fill_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (wr_en && (wr_idx == IW'(i))) begin
          entries_q[i] <= hnd_q;
        end else if (shift[i]) begin
          entries_q[i] <= entries_up[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        fill_q      <= fill_d;
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q <= status_d;
      oh_q     <= oh_d;
      ov_q     <= ov_d;
      drop_q   <= drop_d;
      cnt_q    <= fill_d;
    end
  end

  assign stat_o.out_stall = res_valid_q && !res_ready_i;

  assign res_valid_o   = res_valid_q;
  assign status_o      = status_q;
  assign out_handle_o  = oh_q;
  assign out_valid_o   = ov_q;
  assign dropped_o     = drop_q;
  assign entry_count_o = cnt_q;
  assign is_empty_o    = (cnt_q == '0);

endmodule

FILE: src/bqdp_checker.sv
// Port-level checks on the queue results, bound to the top level.
module bqdp_checker
  import bqdp_pkg::*;
#(
  parameter int unsigned DEPTH       = DEPTH_DEF,
  parameter int unsigned HANDLE_BITS = HANDLE_BITS_DEF,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   res_valid_o,
  input logic                   res_ready_i,
  input logic [1:0]             status_o,
  input logic [HANDLE_BITS-1:0] out_handle_o,
  input logic                   out_valid_o,
  input logic                   dropped_o,
  input logic [CW-1:0]          entry_count_o,
  input logic                   is_empty_o
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o)
    else $error("result withdrawn before it was taken");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (is_empty_o == (entry_count_o == '0)))
    else $error("empty flag disagrees with entry count");

  a_no_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !out_valid_o |-> (out_handle_o == '0) && !dropped_o)
    else $error("handle or drop shown without a handle");

  a_drop_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && dropped_o |-> (status_o == STAT_DONE) && out_valid_o)
    else $error("drop reported with a failing status");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (entry_count_o <= CW'(DEPTH)))
    else $error("entry count beyond queue depth");

endmodule

bind bounded_queue_with_drop_policy_unit bqdp_checker #(
  .DEPTH       (DEPTH),
  .HANDLE_BITS (HANDLE_BITS)
) u_bqdp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_o   (res_valid_o),
  .res_ready_i   (res_ready_i),
  .status_o      (status_o),
  .out_handle_o  (out_handle_o),
  .out_valid_o   (out_valid_o),
  .dropped_o     (dropped_o),
  .entry_count_o (entry_count_o),
  .is_empty_o    (is_empty_o)
);
